### design/ryuv_pkg.sv
package ryuv_pkg;

  // Register file layout
  localparam int unsigned CfgW    = 13;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CntW    = 12;

  localparam logic [CfgIdxW-1:0] CFG_FRAME_WIDTH  = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CfgW-1:0] FrameWidthRst  = 13'd640;
  localparam logic [CfgW-1:0] FrameHeightRst = 13'd480;

  // Q16 color conversion coefficients, rounded to nearest
  localparam int AccW = 27;
  localparam logic signed [AccW-1:0] KyR  = 27'sd19595;
  localparam logic signed [AccW-1:0] KyG  = 27'sd38470;
  localparam logic signed [AccW-1:0] KyB  = 27'sd7471;
  localparam logic signed [AccW-1:0] KuR  = -27'sd11076;
  localparam logic signed [AccW-1:0] KuG  = -27'sd21758;
  localparam logic signed [AccW-1:0] KuB  = 27'sd32768;
  localparam logic signed [AccW-1:0] KvR  = 27'sd32768;
  localparam logic signed [AccW-1:0] KvG  = -27'sd27460;
  localparam logic signed [AccW-1:0] KvB  = -27'sd5308;
  localparam logic signed [AccW-1:0] KOff = 27'sd8388608;  // 128 << 16

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb;
    logic [7:0] cr;
    logic       end_of_frame;
  } yuv_t;

  // Drop the fraction, clamp to 0..255
  function automatic logic [7:0] clamp_q16(input logic signed [AccW-1:0] acc);
    logic [7:0] res;
    if (acc[AccW-1]) begin
      res = 8'd0;
    end else if (|acc[AccW-2:24]) begin
      res = 8'hFF;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

endpackage

### design/ryuv_pix_if.sv
interface ryuv_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink   (input valid, input blue, input green, input red, output ready);
endinterface

### design/ryuv_out_if.sv
interface ryuv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] luma;
  logic       chroma_valid;
  logic [7:0] cb;
  logic [7:0] cr;
  logic       end_of_frame;

  modport source (output valid, output luma, output chroma_valid, output cb, output cr,
                  output end_of_frame, input ready);
  modport sink   (input valid, input luma, input chroma_valid, input cb, input cr,
                  input end_of_frame, output ready);
endinterface

### design/ryuv_csc.sv
module ryuv_csc
  import ryuv_pkg::*;
(
  input  rgb_t pix_i,
  input  logic chroma_en_i,
  input  logic eof_i,
  output yuv_t yuv_o
);

  logic signed [AccW-1:0] r_s, g_s, b_s;
  logic signed [AccW-1:0] y_acc, u_acc, v_acc;

  assign r_s = $signed({{(AccW-8){1'b0}}, pix_i.red});
  assign g_s = $signed({{(AccW-8){1'b0}}, pix_i.green});
  assign b_s = $signed({{(AccW-8){1'b0}}, pix_i.blue});

  // Constant-coefficient sums, exact in AccW bits
  assign y_acc = KyR * r_s + KyG * g_s + KyB * b_s;
  assign u_acc = KuR * r_s + KuG * g_s + KuB * b_s + KOff;
  assign v_acc = KvR * r_s + KvG * g_s + KvB * b_s + KOff;

  always_comb begin
    yuv_o.luma         = clamp_q16(y_acc);
    yuv_o.chroma_valid = chroma_en_i;
    yuv_o.cb           = chroma_en_i ? clamp_q16(u_acc) : 8'd0;
    yuv_o.cr           = chroma_en_i ? clamp_q16(v_acc) : 8'd0;
    yuv_o.end_of_frame = eof_i;
  end

endmodule

### design/rgb_to_yuv420_pixel_converter_core.sv
// RGB to YUV 4:2:0 converter, one pixel per beat in raster order.
// pix_i carries blue, green, red bytes; yuv_o carries one result per pixel:
// luma always, cb/cr with chroma_valid on even column and even row (zero
// otherwise), and end_of_frame on the last pixel of the frame.
// Frame size is set through the write port (index 0 width, index 1 height);
// write it only while the pipe is empty. A value of 0 acts as 1, and values
// above the dimension limit act as the limit.
// Path: a pixel accepted into the input register is converted into the output
// register, from which it is presented on yuv_o.
// Throughput: one pixel per cycle sustained; both stages advance each cycle
// the receiver takes a beat. When the receiver stalls, the output register
// holds its beat and the input stage fills, after which pix_i.ready drops.
// Reset clears the position counters, the stage valids and loads the
// default 640x480 frame size.
module rgb_to_yuv420_pixel_converter_core
  import ryuv_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  ryuv_pix_if.sink           pix_i,
  ryuv_out_if.source         yuv_o
);

  localparam int unsigned CntLimit = 1 << CntW;
  localparam int unsigned DimLimit = (MAX_DIMENSION > CntLimit) ? CntLimit : MAX_DIMENSION;
  localparam logic [CfgW-1:0] DimMax = CfgW'(DimLimit);

  logic [CfgW-1:0] width_q, height_q;
  logic [CntW-1:0] col_q, col_d, row_q, row_d;
  logic [CfgW-1:0] w_eff, h_eff;
  logic            last_col, last_row, chroma_en, eof_now;

  logic s1_v_q;
  rgb_t s1_pix_q;
  logic s1_cv_q, s1_eof_q;
  logic out_v_q;
  yuv_t out_q, csc_res;
  logic s1_en, s2_en, pix_acc;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FrameWidthRst;
      height_q <= FrameHeightRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        CFG_FRAME_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective frame size
  always_comb begin
    w_eff = (width_q == '0) ? CfgW'(1) : ((width_q > DimMax) ? DimMax : width_q);
    h_eff = (height_q == '0) ? CfgW'(1) : ((height_q > DimMax) ? DimMax : height_q);
  end

  // Position tracking
  assign last_col  = {1'b0, col_q} >= (w_eff - CfgW'(1));
  assign last_row  = {1'b0, row_q} >= (h_eff - CfgW'(1));
  assign chroma_en = !col_q[0] && !row_q[0];
  assign eof_now   = last_col && last_row;

  always_comb begin
    col_d = col_q + CntW'(1);
    row_d = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + CntW'(1);
    end
  end

  // Handshake
  assign s2_en       = !out_v_q || yuv_o.ready;
  assign s1_en       = !s1_v_q || s2_en;
  assign pix_i.ready = s1_en;
  assign pix_acc     = pix_i.valid && s1_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (pix_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= pix_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_acc) begin
      s1_pix_q.blue  <= pix_i.blue;
      s1_pix_q.green <= pix_i.green;
      s1_pix_q.red   <= pix_i.red;
      s1_cv_q        <= chroma_en;
      s1_eof_q       <= eof_now;
    end
  end

  ryuv_csc u_csc (
    .pix_i       (s1_pix_q),
    .chroma_en_i (s1_cv_q),
    .eof_i       (s1_eof_q),
    .yuv_o       (csc_res)
  );

  // Output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (s2_en) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_v_q) begin
      out_q <= csc_res;
    end
  end

  assign yuv_o.valid        = out_v_q;
  assign yuv_o.luma         = out_q.luma;
  assign yuv_o.chroma_valid = out_q.chroma_valid;
  assign yuv_o.cb           = out_q.cb;
  assign yuv_o.cr           = out_q.cr;
  assign yuv_o.end_of_frame = out_q.end_of_frame;

`ifndef SYNTH
  // Chroma bytes are zero on beats without chroma
  a_chroma_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    yuv_o.valid && !yuv_o.chroma_valid |-> yuv_o.cb == 8'd0 && yuv_o.cr == 8'd0)
    else $error("cb/cr nonzero without chroma_valid");

  // Last pixel of a frame returns the position to the origin
  a_eof_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_acc && eof_now |=> col_q == '0 && row_q == '0)
    else $error("position not cleared after end of frame");

  // A stalled output beat keeps the input stage from dropping its pixel
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && !yuv_o.ready && s1_v_q |=> s1_v_q && $stable(s1_pix_q))
    else $error("input stage overwritten while output stalled");
`endif

endmodule
